[hdl/lpht_pkg.sv]
package lpht_pkg;

    localparam int SLOTS      = 16;
    localparam int IW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    localparam int CMD_W      = 2;
    localparam int KEY_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int KEY_IDX_W  = $clog2(KEY_W);
    localparam int MOD_CNT_W  = $clog2(KEY_W + 1);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_USED    = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;

    localparam logic [STATUS_W-1:0] RES_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] RES_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] RES_DELETED   = 3'd4;

    typedef struct packed {
        logic [1:0]       st;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic clear;
        logic load;
        logic hash_step;
        logic probe_init;
        logic fetch;
        logic probe;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic nop;
        logic hash_done;
        logic finish;
        logic out_free;
    } t_dp_stat;

endpackage

[hdl/lpht_in_if.sv]
interface lpht_in_if import lpht_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [KEY_W-1:0]        key;

    modport source (output valid, output command, output key, input ready);
    modport sink (input valid, input command, input key, output ready);
endinterface

[hdl/lpht_out_if.sv]
interface lpht_out_if import lpht_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_OUT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink (input valid, input status, input slot_index, output ready);
endinterface

[hdl/lpht_dpath.sv]
module lpht_dpath import lpht_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [CMD_W-1:0]      i_in_command,
    input  logic [KEY_W-1:0]      i_in_key,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_out_status,
    output logic [SLOT_OUT_W-1:0] o_out_slot_index
);

    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_W-1:0]      r_key;
    logic [IW-1:0]         r_mod;
    logic [IW-1:0]         n_mod;
    logic [MOD_CNT_W-1:0]  r_mod_cnt;
    logic [KEY_IDX_W-1:0]  w_bit_idx;
    logic [IW:0]           w_mod_try;
    logic [IW-1:0]         w_home;

    logic [IW-1:0]         r_rd_pos;
    logic [IW-1:0]         r_ev_pos;
    logic [IW-1:0]         r_cnt;
    logic [IW-1:0]         r_clr;

    t_slot                 r_mem [SLOTS];
    t_slot                 r_rdata;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    t_slot                 w_wdata;

    logic                  w_last;
    logic                  w_used;
    logic                  w_empty;
    logic                  w_match;
    logic                  w_finish;
    logic [STATUS_W-1:0]   w_res_status;
    logic [IW-1:0]         w_res_where;

    logic [STATUS_W-1:0]   r_res_status;
    logic [IW-1:0]         r_res_where;

    logic                  r_ov;
    logic [STATUS_W-1:0]   r_o_status;
    logic [SLOT_OUT_W-1:0] r_o_slot;
    logic                  w_out_free;

    // Restoring remainder, one key bit per step, most significant first
    assign w_bit_idx = KEY_IDX_W'(r_mod_cnt - 1'b1);
    assign w_mod_try = {r_mod, r_key[w_bit_idx]};
    assign n_mod     = (w_mod_try >= (IW+1)'(SLOTS)) ? IW'(w_mod_try - (IW+1)'(SLOTS))
                                                     : w_mod_try[IW-1:0];
    assign w_home    = SLOTS_POW2 ? r_key[IW-1:0] : r_mod;

    assign w_last  = (r_cnt == IW'(SLOTS - 1));
    assign w_used  = (r_rdata.st == ST_USED);
    assign w_empty = (r_rdata.st == ST_EMPTY);
    assign w_match = w_used && (r_rdata.key == r_key);

    always_comb begin
        w_finish     = 1'b0;
        w_res_status = RES_NOT_FOUND;
        w_res_where  = r_ev_pos;
        w_we         = 1'b0;
        w_waddr      = r_ev_pos;
        w_wdata      = '{st: ST_USED, key: r_key};
        if (i_cmd.clear) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '{st: ST_EMPTY, key: '0};
        end else if (i_cmd.probe) begin
            case (r_cmd)
                CMD_INSERT: begin
                    if (!w_used) begin
                        w_finish     = 1'b1;
                        w_res_status = RES_INSERTED;
                        w_we         = 1'b1;
                    end else if (w_last) begin
                        w_finish     = 1'b1;
                        w_res_status = RES_FULL;
                        w_res_where  = '0;
                    end
                end
                CMD_SEARCH, CMD_DELETE: begin
                    if (w_match) begin
                        w_finish = 1'b1;
                        if (r_cmd == CMD_DELETE) begin
                            w_res_status = RES_DELETED;
                            w_we         = 1'b1;
                            w_wdata      = '{st: ST_DELETED, key: r_rdata.key};
                        end else begin
                            w_res_status = RES_FOUND;
                        end
                    end else if (w_empty || w_last) begin
                        w_finish    = 1'b1;
                        w_res_where = '0;
                    end
                end
                default: begin
                    w_finish    = 1'b1;
                    w_res_where = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cnt <= '0;
            r_clr     <= '0;
            r_rd_pos  <= '0;
            r_ev_pos  <= '0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load) begin
                r_mod_cnt <= MOD_CNT_W'(KEY_W);
            end else if (i_cmd.hash_step && r_mod_cnt != '0) begin
                r_mod_cnt <= r_mod_cnt - 1'b1;
            end
            if (i_cmd.probe_init) begin
                r_rd_pos <= w_home;
                r_ev_pos <= w_home;
                r_cnt    <= '0;
            end else begin
                if (i_cmd.fetch || i_cmd.probe) begin
                    r_rd_pos <= (r_rd_pos == IW'(SLOTS - 1)) ? '0 : r_rd_pos + 1'b1;
                end
                if (i_cmd.probe) begin
                    r_ev_pos <= (r_ev_pos == IW'(SLOTS - 1)) ? '0 : r_ev_pos + 1'b1;
                    r_cnt    <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_command;
            r_key <= i_in_key;
            r_mod <= '0;
            if (i_in_command == CMD_NONE) begin
                r_res_status <= RES_NOT_FOUND;
                r_res_where  <= '0;
            end
        end else if (i_cmd.hash_step && r_mod_cnt != '0) begin
            r_mod <= n_mod;
        end
        if (w_finish) begin
            r_res_status <= w_res_status;
            r_res_where  <= w_res_where;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_slot   <= SLOT_OUT_W'(r_res_where);
        end
    end

    assign w_out_free = !r_ov || i_out_ready;

    assign o_stat.clr_last  = (r_clr == IW'(SLOTS - 1));
    assign o_stat.nop       = (i_in_command == CMD_NONE);
    assign o_stat.hash_done = SLOTS_POW2 ? 1'b1 : (r_mod_cnt == '0);
    assign o_stat.finish    = w_finish;
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid      = r_ov;
    assign o_out_status     = r_o_status;
    assign o_out_slot_index = r_o_slot;

    a_last_probe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.probe && w_last) |-> w_finish)
        else $error("probe run went past the slot count");

    a_write_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !i_cmd.clear) |-> (i_cmd.probe && w_finish))
        else $error("slot write outside a finishing probe");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_ov)
        else $error("loaded result not presented");

endmodule

[hdl/lpht_ctrl.sv]
module lpht_ctrl import lpht_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_POST  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.nop ? S_POST : S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_FETCH;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_stat.finish) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_cmd.probe || o_cmd.clear || o_cmd.out_load))
        else $error("input taken while busy");

    a_clear_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_stat.clr_last) |=> (r_state == S_IDLE))
        else $error("clear pass did not hand over to idle");

    a_finish_to_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.probe && i_stat.finish) |=> (r_state == S_POST))
        else $error("finished probe did not post its result");

endmodule

[hdl/linear_probe_hash_table.sv]
// Open-addressing hash table, linear probing, one shared slot memory.
// Steps: input transfer, remainder pass over the key bits when SLOTS is not a power
// of two, one fetch, p probes (1 to SLOTS), then the post state loads the result; the
// unused command goes straight to post. One memory read per probe sets the pace; a new
// request is taken only while idle, and an untaken result holds the next one in post.
// Reset: synchronous, active low; a clearing pass empties every slot first.
module linear_probe_hash_table import lpht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_in_if.sink    i_req,
    lpht_out_if.source o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_req.ready = w_in_ready;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpht_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_in_command     (i_req.command),
        .i_in_key         (i_req.key),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_out_status     (o_rsp.status),
        .o_out_slot_index (o_rsp.slot_index)
    );

endmodule

[tb/lpht_checker.sv]
module lpht_checker import lpht_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lpht_in_if    i_req,
    lpht_out_if   i_rsp,
    output int    o_errors,
    output int    o_pending,
    output int    o_checked,
    output int    o_full_seen,
    output int    o_hit_seen
);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot_index;
    } t_answer;

    logic [KEY_W-1:0] tbl_key   [SLOTS];
    logic [1:0]       tbl_state [SLOTS];
    t_answer          expected_answers [$];

    int errors    = 0;
    int checked   = 0;
    int full_seen = 0;
    int hit_seen  = 0;

    assign o_errors    = errors;
    assign o_pending   = expected_answers.size();
    assign o_checked   = checked;
    assign o_full_seen = full_seen;
    assign o_hit_seen  = hit_seen;

    // Apply one command to the shadow table and return the answer it must give.
    function automatic t_answer apply_table_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [KEY_W-1:0] key);
        t_answer     ans;
        int unsigned pos;
        bit          hit;
        bit          stop;
        ans.status     = RES_NOT_FOUND;
        ans.slot_index = '0;
        pos  = key % SLOTS;
        hit  = 1'b0;
        stop = 1'b0;
        case (cmd)
            CMD_INSERT: begin
                ans.status = RES_FULL;
                for (int n = 0; n < SLOTS && !stop; n++) begin
                    if (tbl_state[pos] != ST_USED) begin
                        tbl_key[pos]   = key;
                        tbl_state[pos] = ST_USED;
                        ans.status     = RES_INSERTED;
                        ans.slot_index = pos[SLOT_OUT_W-1:0];
                        stop           = 1'b1;
                    end else begin
                        pos = (pos + 1) % SLOTS;
                    end
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                // tombstones are stepped over, an empty slot ends the probe
                for (int n = 0; n < SLOTS && !stop; n++) begin
                    if (tbl_state[pos] == ST_EMPTY) begin
                        stop = 1'b1;
                    end else if (tbl_state[pos] == ST_USED && tbl_key[pos] == key) begin
                        hit  = 1'b1;
                        stop = 1'b1;
                    end else begin
                        pos = (pos + 1) % SLOTS;
                    end
                end
                if (hit) begin
                    ans.slot_index = pos[SLOT_OUT_W-1:0];
                    if (cmd == CMD_DELETE) begin
                        tbl_state[pos] = ST_DELETED;
                        ans.status     = RES_DELETED;
                    end else begin
                        ans.status = RES_FOUND;
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                tbl_state[s] = ST_EMPTY;
            end
            expected_answers.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                checked++;
                if (i_rsp.status == RES_FULL) begin
                    full_seen++;
                end
                if (i_rsp.status == RES_FOUND || i_rsp.status == RES_DELETED) begin
                    hit_seen++;
                end
                if (expected_answers.size() == 0) begin
                    flag_mismatch("unexpected response, pending count", 0, 1);
                end else begin
                    want = expected_answers.pop_front();
                    if (i_rsp.status != want.status) begin
                        flag_mismatch("status", want.status, i_rsp.status);
                    end
                    if (i_rsp.slot_index != want.slot_index) begin
                        flag_mismatch("slot_index", want.slot_index, i_rsp.slot_index);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_answers.push_back(apply_table_command(i_req.command, i_req.key));
            end
        end
    end

endmodule

[tb/linear_probe_hash_table_tb.sv]
module linear_probe_hash_table_tb import lpht_pkg::*; ();

    localparam int CYCLE_LIMIT = 200000;
    localparam int BLOCKS      = 10;
    localparam int BLOCK_ITEMS = 40;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_mode;

    logic i_clk;
    logic i_rst_n;
    logic stall_en;
    int   cycle_count = 0;
    int   sent        = 0;

    int errors;
    int pending;
    int checked;
    int full_seen;
    int hit_seen;

    logic [KEY_W-1:0] inserted_keys [$];

    lpht_in_if  req_if ();
    lpht_out_if rsp_if ();

    linear_probe_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    lpht_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_seen (full_seen),
        .o_hit_seen  (hit_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response side: drop ready in random bursts while stalling is enabled.
    initial begin : rsp_side
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Present one request, after a random gap when allowed, and hold it until the transfer.
    task automatic send(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                        input bit allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.key     <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (cmd == CMD_INSERT) begin
            inserted_keys.push_back(key);
            if (inserted_keys.size() > 40) begin
                void'(inserted_keys.pop_front());
            end
        end
        sent++;
    endtask

    // Reuse stored keys often so that searches and deletes hit.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && inserted_keys.size() != 0) begin
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        end else if (roll < 60) begin
            return $urandom_range(0, 47);
        end
        return $urandom;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input t_mode mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            return CMD_NONE;
        end
        case (mode)
            MODE_FILL:  return (roll < 80) ? CMD_INSERT : (roll < 90) ? CMD_SEARCH : CMD_DELETE;
            MODE_DRAIN: return (roll < 20) ? CMD_INSERT : (roll < 50) ? CMD_SEARCH : CMD_DELETE;
            default:    return (roll < 40) ? CMD_INSERT : (roll < 75) ? CMD_SEARCH : CMD_DELETE;
        endcase
    endfunction

    initial begin : stimulus
        t_mode mode;
        bit    gaps;
        i_rst_n        <= 1'b0;
        stall_en       <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.command <= CMD_INSERT;
        req_if.key     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        stall_en <= 1'b1;

        // home slot collisions, wrap from the last slot, tombstones, duplicates
        send(CMD_INSERT, 32'h0000_0000, 1'b1);
        send(CMD_INSERT, 32'hFFFF_FFFF, 1'b1);
        send(CMD_INSERT, 32'h8000_0000, 1'b1);
        send(CMD_INSERT, 32'h0000_001F, 1'b1);
        send(CMD_SEARCH, 32'h8000_0000, 1'b1);
        send(CMD_SEARCH, 32'h0000_001F, 1'b1);
        send(CMD_SEARCH, 32'hFFFF_FFFF, 1'b1);
        send(CMD_DELETE, 32'h8000_0000, 1'b1);
        send(CMD_SEARCH, 32'h0000_001F, 1'b1);
        send(CMD_SEARCH, 32'h8000_0000, 1'b1);
        send(CMD_DELETE, 32'h0000_0005, 1'b1);
        send(CMD_NONE,   32'hFFFF_FFFF, 1'b1);
        send(CMD_NONE,   32'h0000_0000, 1'b1);
        send(CMD_INSERT, 32'h0000_0020, 1'b1);
        send(CMD_INSERT, 32'h0000_0000, 1'b1);
        send(CMD_DELETE, 32'h0000_0000, 1'b1);
        send(CMD_SEARCH, 32'h0000_0000, 1'b1);
        send(CMD_DELETE, 32'h0000_001F, 1'b1);
        send(CMD_DELETE, 32'h7FFF_FFF0, 1'b1);

        // fill to overflow first, then drain, then random phases; last blocks run flat out
        for (int b = 0; b < BLOCKS; b++) begin
            if (b == 0) begin
                mode = MODE_FILL;
            end else if (b == 1) begin
                mode = MODE_DRAIN;
            end else begin
                mode = t_mode'($urandom_range(0, 2));
            end
            gaps = (b < BLOCKS - 2) && ($urandom_range(0, 3) != 0);
            stall_en <= gaps;
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
                send(pick_command(mode), pick_key(), gaps);
            end
        end
        req_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d requests sent, %0d responses checked", sent, checked);
        $display("%0d key hits, %0d table-full answers", hit_seen, full_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
